// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks in the generator's RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A check sampled on the rising clock edge and switched off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A check sampled on the rising clock edge that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mtbr_pkg.sv =====
// ----------------------------------------------------------------------------
// mtbr_pkg
// Types and constants shared by the bounded MT19937 generator.
// ----------------------------------------------------------------------------
package mtbr_pkg;

  localparam int MT_SHIFT_M = 397;

  localparam logic [31:0] MT_MATRIX    = 32'h9908_b0df;
  localparam logic [31:0] MT_UPPER     = 32'h8000_0000;
  localparam logic [31:0] MT_LOWER     = 32'h7fff_ffff;
  localparam logic [31:0] MT_TEMPER_B  = 32'h9d2c_5680;
  localparam logic [31:0] MT_TEMPER_C  = 32'hefc6_0000;
  localparam logic [31:0] MT_INIT_MULT = 32'd1812433253;
  localparam logic [31:0] SEED_DEFAULT = 32'd5489;

  localparam logic [1:0] OP_RAW32 = 2'd0;
  localparam logic [1:0] OP_WIDE  = 2'd1;
  localparam logic [1:0] OP_HALF  = 2'd2;
  localparam logic [1:0] OP_BOUND = 2'd3;

  // Requests from the sequencer to the word engine.
  typedef struct packed {
    logic        reseed;
    logic [31:0] seed;
    logic        draw;
  } mtbr_ctrl_t;

  // Status from the word engine back to the sequencer.
  typedef struct packed {
    logic        ready;
    logic        word_valid;
    logic [31:0] word;
  } mtbr_stat_t;

endpackage

// ===== rtl/core/mtbr_twister.sv =====
// ----------------------------------------------------------------------------
// mtbr_twister
// Word store with seed fill and per-word lazy twist, giving tempered draws.
// ----------------------------------------------------------------------------
module mtbr_twister import mtbr_pkg::*; #(
  parameter int STATE_WORDS = 624
) (
  input  logic       clk,
  input  logic       rst,
  input  mtbr_ctrl_t ctrl,
  output mtbr_stat_t stat
);

  localparam int IW       = $clog2(STATE_WORDS);
  localparam int FAR_WRAP = STATE_WORDS - MT_SHIFT_M;

  localparam logic [1:0] T_FILL = 2'd0;
  localparam logic [1:0] T_IDLE = 2'd1;
  localparam logic [1:0] T_USE  = 2'd2;

  logic [31:0] mem [STATE_WORDS];

  logic [1:0]    state;
  logic [IW-1:0] fill_idx;
  logic [31:0]   s;
  logic [31:0]   s_next;
  logic [IW-1:0] k;
  logic [31:0]   cur;
  logic [31:0]   rd_nxt;
  logic [31:0]   rd_far;

  logic [IW-1:0] nxt_idx;
  logic [IW-1:0] far_idx;
  logic [31:0]   y;
  logic [31:0]   twisted;
  logic [31:0]   t1, t2, t3, t4;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          rd_en;

  // Knuth recurrence: one multiply per stored word.
  always_comb begin
    s_next = MT_INIT_MULT * (s ^ (s >> 30)) + 32'(fill_idx) + 32'd1;
  end

  // Twisting word k in place only needs k, k+1 and k+397 as they stand now,
  // which is exactly what a full in-place twist would see at that point.
  always_comb begin
    nxt_idx = (k == IW'(STATE_WORDS - 1)) ? '0 : k + IW'(1);
    far_idx = (k < IW'(FAR_WRAP)) ? k + IW'(MT_SHIFT_M) : k - IW'(FAR_WRAP);
    y       = (cur & MT_UPPER) | (rd_nxt & MT_LOWER);
    twisted = rd_far ^ (y >> 1) ^ (y[0] ? MT_MATRIX : 32'd0);
    t1      = twisted ^ (twisted >> 11);
    t2      = t1 ^ ((t1 << 7) & MT_TEMPER_B);
    t3      = t2 ^ ((t2 << 15) & MT_TEMPER_C);
    t4      = t3 ^ (t3 >> 18);
  end

  assign rd_en     = (state == T_IDLE) && ctrl.draw && !ctrl.reseed;
  assign mem_we    = (state == T_FILL) || (state == T_USE);
  assign mem_waddr = (state == T_FILL) ? fill_idx : k;
  assign mem_wdata = (state == T_FILL) ? s : twisted;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_nxt <= mem[nxt_idx];
      rd_far <= mem[far_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_FILL;
      fill_idx <= '0;
      s        <= SEED_DEFAULT;
      k        <= '0;
    end else if (ctrl.reseed) begin
      state    <= T_FILL;
      fill_idx <= '0;
      s        <= ctrl.seed;
    end else begin
      case (state)
        T_FILL: begin
          // The first stored word also primes the cached copy of entry zero.
          if (fill_idx == '0) begin
            cur <= s;
          end
          s        <= s_next;
          fill_idx <= fill_idx + IW'(1);
          if (fill_idx == IW'(STATE_WORDS - 1)) begin
            state <= T_IDLE;
            k     <= '0;
          end
        end
        T_IDLE: begin
          if (ctrl.draw) begin
            state <= T_USE;
          end
        end
        T_USE: begin
          cur   <= rd_nxt;
          k     <= nxt_idx;
          state <= T_IDLE;
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  assign stat.ready      = (state == T_IDLE);
  assign stat.word_valid = (state == T_USE);
  assign stat.word       = t4;

endmodule

// ===== rtl/core/mt19937_bounded_random.sv =====
// ----------------------------------------------------------------------------
// mt19937_bounded_random
// MT19937 generator returning raw, 64-bit, 63-bit or bounded uniform values.
// ----------------------------------------------------------------------------
// Each input transaction carries an operation and an inclusive bound and
// produces exactly one output transaction with a 64-bit value. A transaction
// is taken when valid is high and stall is low; in_stall stays high while the
// generator is busy with a request or refilling its word store.
// After reset, and after every write on seed_we, the 624-word store is
// refilled from the seed at one word per cycle, and the block takes no request
// until the refill is done. Configuration writes are taken at any time.
// Each 32-bit draw first reads the store, then twists, tempers and writes back
// the word. A raw request uses one draw, a 64-bit or 63-bit request two, and
// a bounded request two per attempt where the bound is above 32 bits and one
// otherwise; rejected attempts draw again. A zero bound draws no word.
// The result sits in an output register, so a stalled receiver does not stop
// the next request being worked on; only its final hand-over waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mt19937_bounded_random import mtbr_pkg::*; #(
  parameter int STATE_WORDS = 624
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [31:0] seed_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [63:0] interval_max,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] random_value
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  mtbr_ctrl_t ctrl;
  mtbr_stat_t stat;

  logic [1:0]  state;
  logic [1:0]  op;
  logic [63:0] bound;
  logic [63:0] mask;
  logic [63:0] mask_next;
  logic [31:0] hi_word;
  logic        second;
  logic [63:0] result;

  logic        in_accept;
  logic        load_out;
  logic        narrow;
  logic [63:0] wide;
  logic [63:0] cand;
  logic        cand_ok;

  mtbr_twister #(
    .STATE_WORDS(STATE_WORDS)
  ) u_twister (
    .clk (clk),
    .rst (rst),
    .ctrl(ctrl),
    .stat(stat)
  );

  assign ctrl.reseed = seed_we;
  assign ctrl.seed   = seed_data;
  assign ctrl.draw   = (state == S_RUN) && stat.ready;

  assign in_stall  = !((state == S_IDLE) && stat.ready);
  assign in_accept = in_valid && !in_stall;
  assign load_out  = (state == S_DONE) && (!out_valid || !out_stall);

  // Smallest all-ones cover of the bound.
  always_comb begin
    mask_next = interval_max;
    for (int i = 0; i < 6; i++) begin
      mask_next = mask_next | (mask_next >> (1 << i));
    end
  end

  always_comb begin
    narrow  = (bound[63:32] == 32'd0);
    wide    = {hi_word, stat.word};
    cand    = (narrow ? {32'd0, stat.word} : wide) & mask;
    cand_ok = (narrow || second) && (cand <= bound);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            op     <= operation;
            bound  <= interval_max;
            mask   <= mask_next;
            second <= 1'b0;
            if ((operation == OP_BOUND) && (interval_max == 64'd0)) begin
              result <= 64'd0;
              state  <= S_DONE;
            end else begin
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (stat.word_valid) begin
            case (op)
              OP_RAW32: begin
                result <= {32'd0, stat.word};
                state  <= S_DONE;
              end
              OP_WIDE, OP_HALF: begin
                if (!second) begin
                  hi_word <= stat.word;
                  second  <= 1'b1;
                end else begin
                  result <= (op == OP_HALF) ? (wide >> 1) : wide;
                  state  <= S_DONE;
                end
              end
              OP_BOUND: begin
                // Wide bounds collect a high word first; a rejected attempt
                // starts over with a fresh pair.
                if (!narrow && !second) begin
                  hi_word <= stat.word;
                  second  <= 1'b1;
                end else begin
                  second <= 1'b0;
                  if (cand_ok) begin
                    result <= cand;
                    state  <= S_DONE;
                  end
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      random_value <= result;
    end
  end

  `ASSERT_CLK_RST(a_word_only_when_running, clk, rst,
    stat.word_valid |-> (state == S_RUN),
    "word delivered while no request is in progress")
  `ASSERT_CLK_RST(a_zero_bound_direct, clk, rst,
    (in_accept && (operation == OP_BOUND) && (interval_max == 64'd0))
      |=> ((state == S_DONE) && (result == 64'd0)),
    "zero bound did not complete at once with zero")
  `ASSERT_CLK_RST(a_out_from_done, clk, rst,
    $rose(out_valid) |-> ($past(state) == S_DONE),
    "output loaded outside the completion state")
  `ASSERT_CLK_RST(a_no_accept_while_reseeding, clk, rst,
    $past(seed_we) |-> !in_accept,
    "request accepted while the word store refills")

endmodule

// ===== bench/tb_mt19937_bounded_random.sv =====
// ----------------------------------------------------------------------------
// tb_mt19937_bounded_random
// Self-checking bench for the bounded MT19937 generator. A software twin of
// the word store predicts every value; results are compared in order.
// ----------------------------------------------------------------------------
// A directed burst covers every operation, the zero bound and the bound edges
// around 32 and 64 bits. Random requests follow in several phases, each after
// a fresh seed, with the request and result sides idling at different rates.
// ----------------------------------------------------------------------------
module tb_mt19937_bounded_random;
  import mtbr_pkg::*;

  localparam int WORD_COUNT  = 624;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 460;

  // Twin of the generator: the word store, its read position and the values
  // still owed by the block, oldest first.
  class value_ledger;
    bit [31:0] words [WORD_COUNT];
    int unsigned position;
    bit [63:0] pending_values [$];
    int fail_count;

    function void seed_words(bit [31:0] s);
      int k;
      for (k = 0; k < WORD_COUNT; k++) begin
        words[k] = s;
        s = MT_INIT_MULT * (s ^ (s >> 30)) + 32'(k) + 32'd1;
      end
      position = WORD_COUNT;
    endfunction

    function void twist_words();
      int k;
      bit [31:0] y;
      for (k = 0; k < WORD_COUNT; k++) begin
        y = (words[k] & MT_UPPER) | (words[(k + 1) % WORD_COUNT] & MT_LOWER);
        words[k] = words[(k + MT_SHIFT_M) % WORD_COUNT] ^ (y >> 1) ^
                   (y[0] ? MT_MATRIX : 32'd0);
      end
      position = 0;
    endfunction

    function bit [31:0] next_word();
      bit [31:0] y;
      if (position >= WORD_COUNT) twist_words();
      y = words[position];
      position++;
      y ^= y >> 11;
      y ^= (y << 7) & MT_TEMPER_B;
      y ^= (y << 15) & MT_TEMPER_C;
      y ^= y >> 18;
      return y;
    endfunction

    function bit [63:0] next_pair();
      bit [31:0] hi;
      bit [31:0] lo;
      hi = next_word();
      lo = next_word();
      return {hi, lo};
    endfunction

    // Draws are masked to the smallest all-ones cover of the bound and
    // drawn again until they fall within it.
    function bit [63:0] pick_within(bit [63:0] bound);
      bit [63:0] mask;
      bit [63:0] v;
      if (bound == 64'd0) return 64'd0;
      mask = bound;
      mask |= mask >> 1;
      mask |= mask >> 2;
      mask |= mask >> 4;
      mask |= mask >> 8;
      mask |= mask >> 16;
      mask |= mask >> 32;
      if (bound <= 64'h0000_0000_ffff_ffff) begin
        do v = {32'd0, next_word()} & mask; while (v > bound);
      end else begin
        do v = next_pair() & mask; while (v > bound);
      end
      return v;
    endfunction

    function void note_request(bit [1:0] op, bit [63:0] bound);
      case (op)
        OP_RAW32: pending_values.push_back({32'd0, next_word()});
        OP_WIDE:  pending_values.push_back(next_pair());
        OP_HALF:  pending_values.push_back(next_pair() >> 1);
        default:  pending_values.push_back(pick_within(bound));
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      fail_count++;
    endtask

    task check_value(bit [63:0] got);
      bit [63:0] want;
      if (pending_values.size() == 0) begin
        report_mismatch($sformatf("random_value %h with no request owed", got));
      end else begin
        want = pending_values.pop_front();
        if (got !== want)
          report_mismatch($sformatf("random_value %h, expected %h", got, want));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        seed_we;
  logic [31:0] seed_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  operation;
  logic [63:0] interval_max;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] random_value;

  value_ledger ledger = new();

  int src_idle_pct;
  int sink_stall_pct;
  int src_calm;
  int sink_calm;
  int cycle_count;

  mt19937_bounded_random dut (
    .clk          (clk),
    .rst          (rst),
    .seed_we      (seed_we),
    .seed_data    (seed_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .interval_max (interval_max),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .random_value (random_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) ledger.note_request(operation, interval_max);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) ledger.check_value(random_value);
  end

  // Result side: stalls at the phase rate, with the odd calm stretch.
  always @(negedge clk) begin
    if (sink_calm > 0) begin
      sink_calm--;
      out_stall = 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) sink_calm = $urandom_range(10, 40);
      out_stall = ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic [1:0] op, input logic [63:0] bound);
    if (src_calm > 0) begin
      src_calm--;
    end else begin
      if ($urandom_range(0, 63) == 0) src_calm = $urandom_range(8, 32);
      while ($urandom_range(0, 99) < src_idle_pct) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid     = 1'b1;
    operation    = op;
    interval_max = bound;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (ledger.pending_values.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    seed_we   = 1'b1;
    seed_data = value;
    ledger.seed_words(value);
    @(negedge clk);
    seed_we = 1'b0;
  endtask

  function automatic logic [63:0] random_bound();
    int unsigned width;
    logic [63:0] full;
    full = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 3));
      1: return {32'd0, full[31:0]};
      2: begin
        width = $urandom_range(1, 32);
        return full >> (64 - width);
      end
      3: return full;
      4: begin
        width = $urandom_range(33, 64);
        return full >> (64 - width);
      end
      default: begin
        // Powers of two and their neighbours sit right at the mask edges.
        width = $urandom_range(0, 63);
        case ($urandom_range(0, 2))
          0:       return 64'd1 << width;
          1:       return (64'd1 << width) - 64'd1;
          default: return (64'd1 << width) + 64'd1;
        endcase
      end
    endcase
  endfunction

  task automatic run_directed();
    send_request(OP_RAW32, 64'd0);
    send_request(OP_RAW32, '1);
    send_request(OP_WIDE,  64'd0);
    send_request(OP_WIDE,  {$urandom, $urandom});
    send_request(OP_HALF,  '1);
    send_request(OP_HALF,  64'd0);
    send_request(OP_BOUND, 64'd0);
    send_request(OP_BOUND, 64'd1);
    send_request(OP_BOUND, 64'd2);
    send_request(OP_BOUND, 64'd3);
    send_request(OP_BOUND, 64'h0000_0000_7fff_ffff);
    send_request(OP_BOUND, 64'h0000_0000_8000_0000);
    send_request(OP_BOUND, 64'h0000_0000_ffff_ffff);
    send_request(OP_BOUND, 64'h0000_0001_0000_0000);
    send_request(OP_BOUND, 64'h0000_0001_0000_0001);
    send_request(OP_BOUND, 64'h7fff_ffff_ffff_ffff);
    send_request(OP_BOUND, 64'h8000_0000_0000_0000);
    send_request(OP_BOUND, 64'h8000_0000_0000_0001);
    send_request(OP_BOUND, '1);
    send_request(OP_BOUND, 64'd0);
  endtask

  task automatic run_random(input int count);
    int n;
    int pick;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 2)      send_request(OP_RAW32, {$urandom, $urandom});
      else if (pick < 4) send_request(OP_WIDE,  {$urandom, $urandom});
      else if (pick < 6) send_request(OP_HALF,  {$urandom, $urandom});
      else               send_request(OP_BOUND, random_bound());
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    seed_we        = 1'b0;
    seed_data      = 32'd0;
    in_valid       = 1'b0;
    operation      = OP_RAW32;
    interval_max   = 64'd0;
    out_stall      = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    src_calm       = 0;
    sink_calm      = 0;
    cycle_count    = 0;
    ledger.seed_words(SEED_DEFAULT);
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // The block refills its store after reset; the handshake holds us off.
    run_directed();

    drain_results();
    write_seed(32'd0);
    run_random(PHASE_ITEMS);

    drain_results();
    write_seed(32'hffff_ffff);
    src_idle_pct = 47;
    run_random(PHASE_ITEMS);

    drain_results();
    write_seed($urandom);
    src_idle_pct   = 0;
    sink_stall_pct = 47;
    run_random(PHASE_ITEMS);

    drain_results();
    write_seed(SEED_DEFAULT);
    src_idle_pct   = 12;
    sink_stall_pct = 12;
    run_random(PHASE_ITEMS);

    drain_results();
    repeat (40) @(posedge clk);
    if (ledger.fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
